// ===== rtl/f2pcm_pkg.sv =====
// Constants and a stage record type for the float to PCM converter.
package f2pcm_pkg;
  localparam int unsigned SCALE = 32767;
  localparam logic [15:0] POS_MAX = 16'h7FFF;
  localparam logic [16:0] NEG_MAX = 17'd32768;

  typedef struct packed {
    logic        neg;
    logic        nan;
    logic        sat;
    logic        zero;
    logic [8:0]  exp;
    logic [38:0] prod;
  } f2pcm_s1_t;
endpackage

// ===== rtl/float_to_pcm_s16_converter.sv =====
// Top level: float32 audio sample to saturated signed 16-bit PCM.
//
// The input channel (float_sample, end_of_buffer, valid, ready) takes one
// float32 bit pattern per transaction. The output channel (pcm_sample,
// end_of_buffer_out, out_valid, out_ready) returns one PCM sample per
// transaction, in order. The sample is scaled by 32767 with float32
// rounding, rounded to an integer, ties to even, and clamped.
// The datapath is a four-stage pipeline: decode and multiply, normalize and
// round to 24 bits, round to integer, saturate into the output register.
// out_valid follows the accepted sample through the stage registers. Throughput
// is one transaction per cycle while the receiver does not stall, since every
// stage is registered and advances when it is empty or the next stage does.
// When the receiver stalls, every stage holds and ready falls only once the
// pipeline is full behind the stalled output; nothing is lost or repeated.
// Synchronous reset clears all valid bits; payload registers are not reset.
module float_to_pcm_s16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] float_sample,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] pcm_sample,
  output logic        end_of_buffer_out
);
  import f2pcm_pkg::*;

  logic [3:0] vld;
  logic [3:0] adv;
  logic [3:0] eob;

  assign adv[3] = !vld[3] || out_ready;
  assign adv[2] = !vld[2] || adv[3];
  assign adv[1] = !vld[1] || adv[2];
  assign adv[0] = !vld[0] || adv[1];
  assign ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // Stage 0: decode and multiply by the scale.
  logic [7:0] ex;
  logic [22:0] man;
  logic [23:0] m;
  f2pcm_s1_t s0;
  assign ex = float_sample[30:23];
  assign man = float_sample[22:0];
  assign m = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0.neg  <= float_sample[31];
      s0.nan  <= (ex == 8'hFF) && (man != '0);
      s0.sat  <= (ex == 8'hFF);
      s0.zero <= (m == '0);
      s0.exp  <= (ex == 8'd0) ? 9'd1 : {1'b0, ex};
      s0.prod <= {15'd0, m} * 39'(SCALE);
      eob[0]  <= end_of_buffer;
    end
  end

  // Stage 1: float32 rounding of the product. Value = prod * 2^(exp-150).
  // The product has 39 bits at most; keep the top 24 of its bit length.
  logic [5:0] nb;
  always_comb begin
    nb = '0;
    for (int i = 0; i < 39; i++) if (s0.prod[i]) nb = 6'(i + 1);
  end
  logic [5:0] sh1;
  logic [38:0] q1_trunc, rem1, half1;
  logic [24:0] q1;
  logic rup1;
  assign sh1 = (nb > 6'd24) ? nb - 6'd24 : 6'd0;
  assign q1_trunc = s0.prod[38:0] >> sh1;
  assign rem1 = s0.prod[38:0] & ((39'd1 << sh1) - 39'd1);
  assign half1 = (sh1 == 0) ? 39'd0 : (39'd1 << (sh1 - 6'd1));
  assign rup1 = (sh1 != 0) && ((rem1 > half1) || ((rem1 == half1) && q1_trunc[0]));
  assign q1 = q1_trunc[24:0] + {24'd0, rup1};

  logic s1_neg, s1_nan, s1_sat, s1_zero;
  logic [24:0] s1_q;
  logic signed [10:0] s1_e2;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_neg  <= s0.neg;
      s1_nan  <= s0.nan;
      // Anything at or above 2^16 saturates either way.
      s1_sat  <= s0.sat || (!s0.zero &&
                 ($signed({5'd0, nb}) + $signed({2'd0, s0.exp}) - 11'sd151 >= 11'sd16));
      s1_zero <= s0.zero ||
                 ($signed({5'd0, nb}) + $signed({2'd0, s0.exp}) - 11'sd150 <= -11'sd1);
      s1_q    <= q1;
      s1_e2   <= $signed({2'd0, s0.exp}) - 11'sd150 + $signed({5'd0, sh1});
      eob[1]  <= eob[0];
    end
  end

  // Stage 2: round to integer. Here e2 lies within -24 .. 1 for kept values.
  logic [5:0] r2;
  logic [24:0] q2_trunc, rem2, half2;
  logic [17:0] mag2;
  logic rup2;
  assign r2 = (s1_e2 < 0) ? 6'(-s1_e2) : 6'd0;
  assign q2_trunc = (r2 > 6'd25) ? 25'd0 : (s1_q >> r2);
  assign rem2 = (r2 > 6'd25) ? s1_q : (s1_q & ((25'd1 << r2) - 25'd1));
  assign half2 = (r2 == 0) ? 25'd0 : ((r2 > 6'd25) ? '1 : (25'd1 << (r2 - 6'd1)));
  assign rup2 = (r2 != 0) && ((rem2 > half2) || ((rem2 == half2) && q2_trunc[0]));
  always_comb begin
    if (s1_e2 >= 0) mag2 = 18'(s1_q << s1_e2[4:0]);
    else mag2 = 18'(q2_trunc) + {17'd0, rup2};
  end

  logic s2_neg, s2_nan, s2_sat;
  logic [17:0] s2_mag;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_neg <= s1_neg;
      s2_nan <= s1_nan;
      s2_sat <= s1_sat;
      s2_mag <= s1_zero ? 18'd0 : mag2;
      eob[2] <= eob[1];
    end
  end

  // Stage 3: saturate, apply the sign, and map NaN to the positive maximum.
  logic [15:0] res;
  always_comb begin
    if (s2_nan) res = POS_MAX;
    else if (s2_neg) begin
      if (s2_sat || s2_mag > {1'b0, NEG_MAX}) res = 16'h8000;
      else res = 16'(18'd0 - s2_mag);
    end else begin
      if (s2_sat || s2_mag > {2'd0, POS_MAX}) res = POS_MAX;
      else res = s2_mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pcm_sample <= res;
      eob[3]     <= eob[2];
    end
  end

  assign out_valid = vld[3];
  assign end_of_buffer_out = eob[3];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pcm_sample))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready)
    else $error("not ready with empty output");
  a_full: assert property (@(posedge clk) disable iff (rst)
    !ready |-> (vld == 4'hF))
    else $error("ready low with a bubble");
endmodule

// ===== dv/float_to_pcm_s16_checker.sv =====
// Checker for the float to PCM converter: predicts each sample and compares results.
module float_to_pcm_s16_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               ready,
  input  logic [31:0]        float_sample,
  input  logic               end_of_buffer,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] pcm_sample,
  input  logic               end_of_buffer_out,
  output int                 fail_count,
  output int                 pending_count
);
  typedef struct {
    logic [15:0] pcm;
    logic        eob;
  } pcm_result_t;

  pcm_result_t expected_pcm_q[$];

  function automatic logic [63:0] round_shift(logic [63:0] v, int r);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = v >> r;
    rem = v & ((64'd1 << r) - 64'd1);
    half = 64'd1 << (r - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [15:0] convert_sample(logic [31:0] bits);
    logic [7:0]  ex;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] mag;
    int          e;
    int          nb;
    int          e2;
    logic        sat;
    ex = bits[30:23];
    sat = 1'b0;
    mag = 64'd0;
    if (ex == 8'hFF && bits[22:0] != 23'd0)
      return 16'h7FFF;
    if (ex == 8'hFF) begin
      sat = 1'b1;
    end else begin
      if (ex == 8'd0) begin
        m = {41'd0, bits[22:0]};
        e = -149;
      end else begin
        m = {40'd0, 1'b1, bits[22:0]};
        e = int'(ex) - 150;
      end
      if (m != 64'd0) begin
        p = m * 64'd32767;
        nb = 0;
        for (int i = 0; i < 64; i++)
          if (p[i]) nb = i + 1;
        if (nb + e - 1 >= 16) begin
          sat = 1'b1;
        end else if (nb + e > -1) begin
          q = p;
          e2 = e;
          if (nb > 24) begin
            q = round_shift(p, nb - 24);
            e2 = e + nb - 24;
          end
          mag = (e2 >= 0) ? (q << e2) : round_shift(q, -e2);
        end
      end
    end
    if (bits[31]) begin
      if (sat || mag > 64'd32768) mag = 64'd32768;
      return 16'(-mag);
    end
    if (sat || mag > 64'd32767) mag = 64'd32767;
    return mag[15:0];
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    pcm_result_t got;
    pcm_result_t want;
    int          errs;
    errs = 0;
    if (!rst) begin
      if (valid && ready) begin
        got.pcm = convert_sample(float_sample);
        got.eob = end_of_buffer;
        expected_pcm_q.push_back(got);
      end
      if (out_valid && out_ready) begin
        if (expected_pcm_q.size() == 0) begin
          $error("unexpected transaction: pcm_sample %0d", pcm_sample);
          errs = errs + 1;
        end else begin
          want = expected_pcm_q.pop_front();
          if (pcm_sample !== want.pcm) begin
            $error("pcm_sample: expected %0d actual %0d",
                   $signed(want.pcm), pcm_sample);
            errs = errs + 1;
          end
          if (end_of_buffer_out !== want.eob) begin
            $error("end_of_buffer_out: expected %0b actual %0b",
                   want.eob, end_of_buffer_out);
            errs = errs + 1;
          end
        end
      end
    end
    fail_count <= fail_count + errs;
    pending_count <= expected_pcm_q.size();
  end
endmodule

// ===== dv/tb_float_to_pcm_s16_converter.sv =====
// Testbench top for the float to PCM converter: stimulus, flow control and verdict.
module tb_float_to_pcm_s16_converter;
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               valid = 1'b0;
  logic               ready;
  logic [31:0]        float_sample = 32'd0;
  logic               end_of_buffer = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] pcm_sample;
  logic               end_of_buffer_out;
  int                 fail_count;
  int                 pending_count;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  logic               hold_off = 1'b0;

  always #4 clk = ~clk;

  float_to_pcm_s16_converter DUT (.*);

  float_to_pcm_s16_checker checker_i (.*);

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so transactions can follow back to back.
  task automatic send_sample(logic [31:0] bits, logic eob);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    float_sample <= bits;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Half of the draws near the audio range or above it; the rest raw bit patterns and edge exponents.
  function automatic logic [31:0] random_sample();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(5))
      0, 1: b[30:23] = 8'($urandom_range(110, 127));
      2: b[30:23] = 8'($urandom_range(127, 145));
      3: b[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return b;
  endfunction

  always @(negedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000,
                 32'h3F00_0100, 32'h3800_0000, 32'h3800_4000, 32'h3F7F_FFFF,
                 32'hBF7F_FFFF, 32'h4000_0000, 32'hC000_0000, 32'h7F7F_FFFF,
                 32'hFF7F_FFFF, 32'h3F00_0080, 32'hBF00_0080};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_sample(directed[i], i[0]);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 12 : 59) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 12 : 59) : 0;
      for (int n = 0; n < 450; n++) send_sample(random_sample(), 1'($urandom));
      valid <= 1'b0;
      // Let the output drain completely before the next phase.
      while (pending_count != 0) @(negedge clk);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 40; n++) send_sample(random_sample(), 1'($urandom));
    join
    valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("** float_to_pcm_s16_converter: PASSED **");
    else
      $display("** float_to_pcm_s16_converter: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** float_to_pcm_s16_converter: FAILED **");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/f2pcm_pkg.sv
rtl/float_to_pcm_s16_converter.sv
dv/float_to_pcm_s16_checker.sv
dv/tb_float_to_pcm_s16_converter.sv
